// ===== rtl/core/btms_pkg.sv =====
package btms_pkg;

  // batch size and field widths
  localparam int unsigned SAMPLES  = 12;
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned MAIN_W   = 17;
  localparam int unsigned BACKUP_W = 13;
  localparam int unsigned OFF_W    = 11;
  localparam int unsigned THR_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_LOW    = 2'd3;

  // config reset values
  localparam logic [OFF_W-1:0] MAIN_OFFSET_RST   = 11'd400;
  localparam logic [OFF_W-1:0] BACKUP_OFFSET_RST = 11'd440;
  localparam logic [THR_W-1:0] BACKUP_HIGH_RST   = 13'd4000;
  localparam logic [THR_W-1:0] BACKUP_LOW_RST    = 13'd3900;

  // sleep action codes
  localparam logic [1:0] ACT_KEEP  = 2'd0;
  localparam logic [1:0] ACT_LIGHT = 2'd1;
  localparam logic [1:0] ACT_DEEP  = 2'd2;

  // Q16 scale factors in mV per count
  localparam logic [19:0] MAIN_K   = 20'd885166;
  localparam logic [16:0] BACKUP_K = 17'd80020;

  // divide by the trimmed count through an exact reciprocal for 20-bit values
  localparam longint unsigned DIV_D   = SAMPLES - 2;
  localparam int unsigned     DIV_L   = $clog2(DIV_D);
  localparam int unsigned     X_W     = 20;
  localparam int unsigned     DIV_SH  = X_W + DIV_L;
  localparam longint unsigned DIV_REC = ((64'd1 << DIV_SH) + DIV_D - 64'd1) / DIV_D;
  localparam int unsigned     REC_W   = X_W + 1;

  // divide by 1000 for 16-bit values
  localparam int unsigned     WH_SH  = 26;
  localparam longint unsigned WH_REC = ((64'd1 << WH_SH) + 64'd999) / 64'd1000;

  // divide by 20 for 13-bit values
  localparam int unsigned     BR_SH  = 18;
  localparam longint unsigned BR_REC = ((64'd1 << BR_SH) + 64'd19) / 64'd20;

  // divide by 1000000 for 29-bit values
  localparam int unsigned     RP_SH  = 49;
  localparam longint unsigned RP_REC = ((64'd1 << RP_SH) + 64'd999999) / 64'd1000000;
  localparam logic [12:0]     RP_K   = 13'd6667;

  // trimmed sums handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] main_trim;
    logic [SUM_W-1:0] backup_trim;
  } trim_t;

  // live configuration
  typedef struct packed {
    logic [OFF_W-1:0] main_offset;
    logic [OFF_W-1:0] backup_offset;
    logic [THR_W-1:0] backup_high;
    logic [THR_W-1:0] backup_low;
  } cfg_t;

  // wake interval per band
  function automatic logic [18:0] wake_of(input logic [2:0] band);
    logic [18:0] w;
    case (band)
      3'd0:    w = 19'd10800;
      3'd1:    w = 19'd43200;
      3'd2:    w = 19'd86400;
      3'd3:    w = 19'd172800;
      3'd4:    w = 19'd259200;
      3'd5:    w = 19'd345600;
      default: w = 19'd432000;
    endcase
    return w;
  endfunction

  // sleep action per band
  function automatic logic [1:0] action_of(input logic [2:0] band);
    logic [1:0] a;
    case (band)
      3'd0, 3'd1:       a = ACT_KEEP;
      3'd2, 3'd3, 3'd4: a = ACT_LIGHT;
      default:          a = ACT_DEEP;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/btms_front.sv =====
module btms_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [btms_pkg::RAW_W-1:0]   main_raw_i,
  input  logic [btms_pkg::RAW_W-1:0]   backup_raw_i,
  output logic                         push_o,
  output btms_pkg::trim_t              push_data_o
);

  logic [btms_pkg::CNT_W-1:0] cnt_q;
  logic [btms_pkg::SUM_W-1:0] m_sum_q, b_sum_q, m_sum_d, b_sum_d;
  logic [btms_pkg::RAW_W-1:0] m_min_q, m_max_q, b_min_q, b_max_q;
  logic [btms_pkg::RAW_W-1:0] m_min_d, m_max_d, b_min_d, b_max_d;
  logic                       last;

  // running sums, minima and maxima including the new item
  always_comb begin
    m_sum_d = m_sum_q + btms_pkg::SUM_W'(main_raw_i);
    b_sum_d = b_sum_q + btms_pkg::SUM_W'(backup_raw_i);
    m_min_d = (main_raw_i < m_min_q) ? main_raw_i : m_min_q;
    m_max_d = (main_raw_i > m_max_q) ? main_raw_i : m_max_q;
    b_min_d = (backup_raw_i < b_min_q) ? backup_raw_i : b_min_q;
    b_max_d = (backup_raw_i > b_max_q) ? backup_raw_i : b_max_q;
  end

  assign last = (cnt_q == btms_pkg::CNT_W'(btms_pkg::SAMPLES - 1));

  // trimmed sums go out on the last item of a batch
  assign push_o = accept_i && last;
  assign push_data_o.main_trim = m_sum_d - btms_pkg::SUM_W'(m_min_d)
                                 - btms_pkg::SUM_W'(m_max_d);
  assign push_data_o.backup_trim = b_sum_d - btms_pkg::SUM_W'(b_min_d)
                                   - btms_pkg::SUM_W'(b_max_d);

  // batch accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      m_sum_q <= '0;
      b_sum_q <= '0;
      m_min_q <= '1;
      m_max_q <= '0;
      b_min_q <= '1;
      b_max_q <= '0;
    end else if (accept_i) begin
      if (last) begin
        cnt_q   <= '0;
        m_sum_q <= '0;
        b_sum_q <= '0;
        m_min_q <= '1;
        m_max_q <= '0;
        b_min_q <= '1;
        b_max_q <= '0;
      end else begin
        cnt_q   <= cnt_q + 1'b1;
        m_sum_q <= m_sum_d;
        b_sum_q <= b_sum_d;
        m_min_q <= m_min_d;
        m_max_q <= m_max_d;
        b_min_q <= b_min_d;
        b_max_q <= b_max_d;
      end
    end
  end

endmodule

// ===== rtl/core/btms_queue.sv =====
module btms_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  btms_pkg::trim_t  push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output btms_pkg::trim_t  data_o
);

  btms_pkg::trim_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/btms_back.sv =====
module btms_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  btms_pkg::cfg_t                      cfg_i,
  input  logic                                q_valid_i,
  input  btms_pkg::trim_t                     q_data_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [btms_pkg::MAIN_W-1:0]  main_mv_o,
  output logic [btms_pkg::BACKUP_W-1:0]       backup_mv_o,
  output logic [5:0]                          main_whole_volts_o,
  output logic [8:0]                          main_report_o,
  output logic [8:0]                          backup_report_o,
  output logic [2:0]                          supply_band_o,
  output logic [18:0]                         wake_interval_s_o,
  output logic [1:0]                          sleep_action_o
);

  localparam int unsigned PM_W = btms_pkg::SUM_W + 20;
  localparam int unsigned PB_W = btms_pkg::SUM_W + 17;
  localparam int unsigned PQ_W = btms_pkg::X_W + btms_pkg::REC_W;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;

  logic [PM_W-1:0] pm1_q;
  logic [PB_W-1:0] pb1_q;
  logic [PQ_W-1:0] qm2_q, qb2_q;
  logic signed [btms_pkg::MAIN_W-1:0] mmv3_q, mmv4_q, mmv5_q;
  logic [btms_pkg::BACKUP_W-1:0] bmv3_q, bmv4_q, bmv5_q;
  logic [2:0]  band4_q, band5_q;
  logic [32:0] wp4_q;
  logic [28:0] rp4_q;
  logic [26:0] bp4_q;
  logic [5:0]  whole5_q;
  logic [8:0]  brep5_q;
  logic [58:0] rp5_q;

  logic signed [btms_pkg::MAIN_W-1:0] main_mv_q;
  logic [btms_pkg::BACKUP_W-1:0]      backup_mv_q;
  logic [5:0]                         main_whole_volts_q;
  logic [8:0]                         main_report_q;
  logic [8:0]                         backup_report_q;
  logic [2:0]                         supply_band_q;
  logic [18:0]                        wake_interval_s_q;
  logic [1:0]                         sleep_action_q;

  logic [btms_pkg::X_W-1:0] xm2, xb2;
  logic [15:0] qm3;
  logic [12:0] qb3;
  logic signed [btms_pkg::MAIN_W-1:0] mmv3_d, t1, t2, t3, t4;
  logic [2:0]  band4_d;
  logic [15:0] pos4;

  // the whole pipeline moves unless a result waits at the output
  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // stage 2 and 3 operands
  assign xm2 = pm1_q[PM_W-1:16];
  assign xb2 = btms_pkg::X_W'(pb1_q[PB_W-1:16]);
  assign qm3 = 16'(qm2_q >> btms_pkg::DIV_SH);
  assign qb3 = 13'(qb2_q >> btms_pkg::DIV_SH);
  assign mmv3_d = $signed({1'b0, qm3}) - $signed({6'b0, cfg_i.main_offset});

  // threshold profile and band
  always_comb begin
    if (mmv3_q >= 17'sd16000 && mmv3_q < 17'sd36000) begin
      t1 = 17'sd24000; t2 = 17'sd23000; t3 = 17'sd22000; t4 = 17'sd21000;
    end else if (mmv3_q > 17'sd4000 && mmv3_q < 17'sd16000) begin
      t1 = 17'sd12000; t2 = 17'sd11000; t3 = 17'sd10000; t4 = 17'sd9000;
    end else begin
      t1 = 17'sd32000; t2 = 17'sd32000; t3 = 17'sd32000; t4 = 17'sd32000;
    end
    if (mmv3_q > t1)                    band4_d = 3'd0;
    else if (mmv3_q > t2)               band4_d = 3'd1;
    else if (mmv3_q > t3)               band4_d = 3'd2;
    else if (mmv3_q > t4)               band4_d = 3'd3;
    else if (bmv3_q > cfg_i.backup_high) band4_d = 3'd4;
    else if (bmv3_q > cfg_i.backup_low)  band4_d = 3'd5;
    else                                band4_d = 3'd6;
  end

  // negative main supply reports as zero
  assign pos4 = mmv3_q[btms_pkg::MAIN_W-1] ? 16'd0 : mmv3_q[15:0];

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // scale trimmed sums to Q16 millivolts
      pm1_q <= PM_W'(q_data_i.main_trim) * PM_W'(btms_pkg::MAIN_K);
      pb1_q <= PB_W'(q_data_i.backup_trim) * PB_W'(btms_pkg::BACKUP_K);
      // divide by the trimmed count
      qm2_q <= PQ_W'(xm2) * PQ_W'(btms_pkg::DIV_REC);
      qb2_q <= PQ_W'(xb2) * PQ_W'(btms_pkg::DIV_REC);
      // apply offsets
      mmv3_q <= mmv3_d;
      bmv3_q <= qb3 + btms_pkg::BACKUP_W'(cfg_i.backup_offset);
      // classify and start the report scalings
      mmv4_q  <= mmv3_q;
      bmv4_q  <= bmv3_q;
      band4_q <= band4_d;
      wp4_q   <= 33'(pos4) * 33'(btms_pkg::WH_REC);
      rp4_q   <= 29'(pos4) * 29'(btms_pkg::RP_K);
      bp4_q   <= 27'(bmv3_q) * 27'(btms_pkg::BR_REC);
      // finish divisions by constants
      mmv5_q   <= mmv4_q;
      bmv5_q   <= bmv4_q;
      band5_q  <= band4_q;
      whole5_q <= 6'(wp4_q >> btms_pkg::WH_SH);
      brep5_q  <= 9'(bp4_q >> btms_pkg::BR_SH);
      rp5_q    <= 59'(rp4_q) * 59'(btms_pkg::RP_REC);
      // output register
      main_mv_q          <= mmv5_q;
      backup_mv_q        <= bmv5_q;
      main_whole_volts_q <= whole5_q;
      main_report_q      <= 9'(rp5_q >> btms_pkg::RP_SH);
      backup_report_q    <= brep5_q;
      supply_band_q      <= band5_q;
      wake_interval_s_q  <= btms_pkg::wake_of(band5_q);
      sleep_action_q     <= btms_pkg::action_of(band5_q);
    end
  end

  // result ports
  assign out_valid_o        = out_valid_q;
  assign main_mv_o          = main_mv_q;
  assign backup_mv_o        = backup_mv_q;
  assign main_whole_volts_o = main_whole_volts_q;
  assign main_report_o      = main_report_q;
  assign backup_report_o    = backup_report_q;
  assign supply_band_o      = supply_band_q;
  assign wake_interval_s_o  = wake_interval_s_q;
  assign sleep_action_o     = sleep_action_q;

endmodule

// ===== rtl/core/battery_trimmed_mean_sleep_policy.sv =====
// result path: the item that closes a batch goes into the queue, then through the pipeline to the output register
// throughput: one item per cycle while the queue is not full; one result per batch of 12 items
// the six-stage scaling pipeline behind a two-entry queue sets the latency
// reset: batch accumulators clear, offsets and thresholds take their defaults,
// queue and pipeline empty
module battery_trimmed_mean_sleep_policy (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [btms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [btms_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [btms_pkg::RAW_W-1:0]          main_raw_i,
  input  logic [btms_pkg::RAW_W-1:0]          backup_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [btms_pkg::MAIN_W-1:0]  main_mv_o,
  output logic [btms_pkg::BACKUP_W-1:0]       backup_mv_o,
  output logic [5:0]                          main_whole_volts_o,
  output logic [8:0]                          main_report_o,
  output logic [8:0]                          backup_report_o,
  output logic [2:0]                          supply_band_o,
  output logic [18:0]                         wake_interval_s_o,
  output logic [1:0]                          sleep_action_o
);

  btms_pkg::cfg_t  cfg_q;
  btms_pkg::trim_t push_data, q_data;
  logic            push, q_full, q_valid, q_pop, in_accept;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.main_offset   <= btms_pkg::MAIN_OFFSET_RST;
      cfg_q.backup_offset <= btms_pkg::BACKUP_OFFSET_RST;
      cfg_q.backup_high   <= btms_pkg::BACKUP_HIGH_RST;
      cfg_q.backup_low    <= btms_pkg::BACKUP_LOW_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        btms_pkg::CFG_MAIN_OFFSET:   cfg_q.main_offset   <= cfg_data_i[btms_pkg::OFF_W-1:0];
        btms_pkg::CFG_BACKUP_OFFSET: cfg_q.backup_offset <= cfg_data_i[btms_pkg::OFF_W-1:0];
        btms_pkg::CFG_BACKUP_HIGH:   cfg_q.backup_high   <= cfg_data_i;
        btms_pkg::CFG_BACKUP_LOW:    cfg_q.backup_low    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake: samples are taken only while the queue has room for a batch result
  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && in_ready_o;

  btms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .main_raw_i   (main_raw_i),
    .backup_raw_i (backup_raw_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  btms_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  btms_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .q_data_i           (q_data),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .main_mv_o          (main_mv_o),
    .backup_mv_o        (backup_mv_o),
    .main_whole_volts_o (main_whole_volts_o),
    .main_report_o      (main_report_o),
    .backup_report_o    (backup_report_o),
    .supply_band_o      (supply_band_o),
    .wake_interval_s_o  (wake_interval_s_o),
    .sleep_action_o     (sleep_action_o)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // settle time after the last report before touching the registers
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_BATCHES = 18;

  typedef enum logic [2:0] {
    BAND_FULL,
    BAND_GOOD,
    BAND_FAIR,
    BAND_LOW,
    BAND_BACKUP_OK,
    BAND_BACKUP_WEAK,
    BAND_EXHAUSTED
  } band_e;

  typedef struct packed {
    logic signed [btms_pkg::MAIN_W-1:0] main_mv;
    logic [btms_pkg::BACKUP_W-1:0]      backup_mv;
    logic [5:0]                         whole_volts;
    logic [8:0]                         main_report;
    logic [8:0]                         backup_report;
    logic [2:0]                         band;
    logic [18:0]                        wake_s;
    logic [1:0]                         action;
  } supply_report_t;

  typedef struct packed {
    logic [btms_pkg::RAW_W-1:0] main_raw;
    logic [btms_pkg::RAW_W-1:0] backup_raw;
    logic                       typed;
    supply_report_t             want;
  } sample_row_t;

  localparam supply_report_t NONE = '0;
  // all-zero batch: offsets alone, exhausted band
  localparam supply_report_t DRAINED = '{-17'sd400, 13'd440, 6'd0, 9'd0, 9'd22,
                                         BAND_EXHAUSTED, 19'd432000, btms_pkg::ACT_DEEP};
  // full-scale batch under the fallback profile
  localparam supply_report_t TOPPED = '{17'sd54909, 13'd5440, 6'd54, 9'd366, 9'd272,
                                        BAND_FULL, 19'd10800, btms_pkg::ACT_KEEP};

  // two batches: outliers at the extremes get trimmed away
  localparam sample_row_t WARMUP [24] = '{
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'hFFF, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'hFFF, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b0, NONE},
    '{12'h000, 12'h000, 1'b1, DRAINED},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'h000, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'h000, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b0, NONE},
    '{12'hFFF, 12'hFFF, 1'b1, TOPPED}
  };

  localparam logic [18:0] WAKE_BY_BAND [7] = '{19'd10800, 19'd43200, 19'd86400, 19'd172800,
                                               19'd259200, 19'd345600, 19'd432000};

  // main supply targets around the profile and band edges
  localparam int MAIN_MARKS [12] = '{0, 4000, 9000, 10000, 11000, 12000, 16000,
                                     21000, 22000, 23000, 24000, 36000};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [btms_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [btms_pkg::CFG_DAT_W-1:0]     cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [btms_pkg::RAW_W-1:0]         main_raw_i;
  logic [btms_pkg::RAW_W-1:0]         backup_raw_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [btms_pkg::MAIN_W-1:0] main_mv_o;
  logic [btms_pkg::BACKUP_W-1:0]      backup_mv_o;
  logic [5:0]                         main_whole_volts_o;
  logic [8:0]                         main_report_o;
  logic [8:0]                         backup_report_o;
  logic [2:0]                         supply_band_o;
  logic [18:0]                        wake_interval_s_o;
  logic [1:0]                         sleep_action_o;

  // batch accumulators and live registers of the predictor
  logic [btms_pkg::SUM_W-1:0] main_acc;
  logic [btms_pkg::SUM_W-1:0] backup_acc;
  logic [btms_pkg::RAW_W-1:0] main_lo;
  logic [btms_pkg::RAW_W-1:0] main_hi;
  logic [btms_pkg::RAW_W-1:0] backup_lo;
  logic [btms_pkg::RAW_W-1:0] backup_hi;
  int unsigned                batch_fill;
  btms_pkg::cfg_t             live_cfg;

  supply_report_t report_q[$];
  int unsigned    fail_count = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    ready_left = 0;
  bit             idle_on = 1'b1;
  bit             pause_pending = 1'b0;

  battery_trimmed_mean_sleep_policy u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .main_raw_i        (main_raw_i),
    .backup_raw_i      (backup_raw_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .main_mv_o         (main_mv_o),
    .backup_mv_o       (backup_mv_o),
    .main_whole_volts_o(main_whole_volts_o),
    .main_report_o     (main_report_o),
    .backup_report_o   (backup_report_o),
    .supply_band_o     (supply_band_o),
    .wake_interval_s_o (wake_interval_s_o),
    .sleep_action_o    (sleep_action_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void clear_accumulators();
    batch_fill = 0;
    main_acc   = '0;
    backup_acc = '0;
    main_lo    = '1;
    main_hi    = '0;
    backup_lo  = '1;
    backup_hi  = '0;
  endfunction

  // fold one sample pair into the batch; on the last pair grade the supply
  function automatic bit absorb_sample(input logic [btms_pkg::RAW_W-1:0] m,
                                       input logic [btms_pkg::RAW_W-1:0] b,
                                       output supply_report_t r);
    longint mtrim, btrim, mmv, bmv, div;
    longint t1, t2, t3, t4;
    band_e  band;
    main_acc   = main_acc + m;
    backup_acc = backup_acc + b;
    if (m < main_lo) main_lo = m;
    if (m > main_hi) main_hi = m;
    if (b < backup_lo) backup_lo = b;
    if (b > backup_hi) backup_hi = b;
    if (batch_fill + 1 < btms_pkg::SAMPLES) begin
      batch_fill++;
      return 1'b0;
    end
    div   = longint'((btms_pkg::SAMPLES > 2) ? btms_pkg::SAMPLES - 2 : 1) << 16;
    mtrim = longint'(main_acc) - longint'(main_lo) - longint'(main_hi);
    btrim = longint'(backup_acc) - longint'(backup_lo) - longint'(backup_hi);
    mmv   = (mtrim * 885166) / div - longint'(live_cfg.main_offset);
    bmv   = (btrim * 80020) / div + longint'(live_cfg.backup_offset);
    clear_accumulators();
    // threshold profile from the main supply level
    if (mmv >= 16000 && mmv < 36000) begin
      t1 = 24000; t2 = 23000; t3 = 22000; t4 = 21000;
    end else if (mmv > 4000 && mmv < 16000) begin
      t1 = 12000; t2 = 11000; t3 = 10000; t4 = 9000;
    end else begin
      t1 = 32000; t2 = 32000; t3 = 32000; t4 = 32000;
    end
    if (mmv > t1) band = BAND_FULL;
    else if (mmv > t2) band = BAND_GOOD;
    else if (mmv > t3) band = BAND_FAIR;
    else if (mmv > t4) band = BAND_LOW;
    else if (bmv > longint'(live_cfg.backup_high)) band = BAND_BACKUP_OK;
    else if (bmv > longint'(live_cfg.backup_low)) band = BAND_BACKUP_WEAK;
    else band = BAND_EXHAUSTED;
    r.main_mv       = mmv[btms_pkg::MAIN_W-1:0];
    r.backup_mv     = bmv[btms_pkg::BACKUP_W-1:0];
    r.whole_volts   = (mmv < 0) ? 6'd0 : 6'(mmv / 1000);
    r.main_report   = (mmv < 0) ? 9'd0 : 9'((mmv * 6667) / 1000000);
    r.backup_report = 9'((bmv * 50) / 1000);
    r.band          = band;
    r.wake_s        = WAKE_BY_BAND[band];
    if (band <= BAND_GOOD) r.action = btms_pkg::ACT_KEEP;
    else if (band <= BAND_BACKUP_OK) r.action = btms_pkg::ACT_LIGHT;
    else r.action = btms_pkg::ACT_DEEP;
    return 1'b1;
  endfunction

  function automatic logic [btms_pkg::RAW_W-1:0] clamp_raw(input longint v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return btms_pkg::RAW_W'(v);
  endfunction

  // per-sample code whose scaled mean lands at the wanted millivolts
  function automatic logic [btms_pkg::RAW_W-1:0] raw_toward(input longint mv, input longint k);
    return clamp_raw((mv * 65536) / k);
  endfunction

  function automatic logic [btms_pkg::RAW_W-1:0] nudge(input logic [btms_pkg::RAW_W-1:0] c,
                                                       input int j);
    return clamp_raw(longint'(c) + longint'(int'($urandom_range(0, 2 * j)) - j));
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // present one sample pair, with an occasional gap in front of it
  task automatic send_sample(input logic [btms_pkg::RAW_W-1:0] m,
                             input logic [btms_pkg::RAW_W-1:0] b,
                             input bit typed, input supply_report_t want);
    supply_report_t got;
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    main_raw_i   <= m;
    backup_raw_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (absorb_sample(m, b, got)) report_q.push_back(typed ? want : got);
  endtask

  // hold the sender until every pending report is out
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [btms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [btms_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      btms_pkg::CFG_MAIN_OFFSET:   live_cfg.main_offset   = data[btms_pkg::OFF_W-1:0];
      btms_pkg::CFG_BACKUP_OFFSET: live_cfg.backup_offset = data[btms_pkg::OFF_W-1:0];
      btms_pkg::CFG_BACKUP_HIGH:   live_cfg.backup_high   = data[btms_pkg::THR_W-1:0];
      default:                     live_cfg.backup_low    = data[btms_pkg::THR_W-1:0];
    endcase
  endtask

  task automatic program_limits(input logic [btms_pkg::CFG_DAT_W-1:0] main_off,
                                input logic [btms_pkg::CFG_DAT_W-1:0] backup_off,
                                input logic [btms_pkg::CFG_DAT_W-1:0] high_mv,
                                input logic [btms_pkg::CFG_DAT_W-1:0] low_mv);
    write_reg(btms_pkg::CFG_MAIN_OFFSET, main_off);
    write_reg(btms_pkg::CFG_BACKUP_OFFSET, backup_off);
    write_reg(btms_pkg::CFG_BACKUP_HIGH, high_mv);
    write_reg(btms_pkg::CFG_BACKUP_LOW, low_mv);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one batch aimed at a supply level, with jitter and an odd outlier
  task automatic play_batch();
    logic [btms_pkg::RAW_W-1:0] mc, bc, m, b;
    longint mt, bt;
    int mj, bj, main_odd, backup_odd;
    bit noise;
    noise = ($urandom_range(0, 9) < 2);
    if ($urandom_range(0, 3) == 0) mt = $urandom_range(0, 56000);
    else mt = MAIN_MARKS[$urandom_range(0, 11)] + int'($urandom_range(0, 80)) - 40;
    case ($urandom_range(0, 2))
      0:       bt = $urandom_range(0, 7500);
      1:       bt = longint'(live_cfg.backup_high) + int'($urandom_range(0, 24)) - 12;
      default: bt = longint'(live_cfg.backup_low) + int'($urandom_range(0, 24)) - 12;
    endcase
    mc = raw_toward(mt + longint'(live_cfg.main_offset), 885166);
    bc = raw_toward(bt - longint'(live_cfg.backup_offset), 80020);
    mj = $urandom_range(0, 3);
    bj = $urandom_range(0, 3);
    main_odd   = $urandom_range(0, 2 * btms_pkg::SAMPLES - 1);
    backup_odd = $urandom_range(0, 2 * btms_pkg::SAMPLES - 1);
    for (int k = 0; k < btms_pkg::SAMPLES; k++) begin
      if (noise || k == main_odd) m = $urandom_range(0, 4095);
      else m = nudge(mc, mj);
      if (noise || k == backup_odd) b = $urandom_range(0, 4095);
      else b = nudge(bc, bj);
      if (pause_pending && k == btms_pkg::SAMPLES / 2) begin
        drain_reports();
        pause_pending = 1'b0;
      end
      send_sample(m, b, 1'b0, NONE);
    end
  endtask

  // receiver: ready in random bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_on) begin
      out_ready_i <= 1'b1;
    end else if (ready_left != 0) begin
      ready_left = ready_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready_i <= 1'b0;
      ready_left = $urandom_range(1, 18);
    end else begin
      out_ready_i <= 1'b1;
      ready_left = $urandom_range(1, 30);
    end
  end

  // compare each delivered report with the oldest prediction
  always @(posedge clk_i) begin : report_check
    supply_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) begin
        $display("%0t report with nothing pending: expected none, actual main_mv %0d",
                 $time, main_mv_o);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        check_field("main_mv", want.main_mv, main_mv_o);
        check_field("backup_mv", want.backup_mv, backup_mv_o);
        check_field("main_whole_volts", want.whole_volts, main_whole_volts_o);
        check_field("main_report", want.main_report, main_report_o);
        check_field("backup_report", want.backup_report, backup_report_o);
        check_field("supply_band", want.band, supply_band_o);
        check_field("wake_interval_s", want.wake_s, wake_interval_s_o);
        check_field("sleep_action", want.action, sleep_action_o);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    main_raw_i   = '0;
    backup_raw_i = '0;
    out_ready_i  = 1'b0;
    clear_accumulators();
    live_cfg.main_offset   = 11'd400;
    live_cfg.backup_offset = 11'd440;
    live_cfg.backup_high   = 13'd4000;
    live_cfg.backup_low    = 13'd3900;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed batches at reset settings
    foreach (WARMUP[i])
      send_sample(WARMUP[i].main_raw, WARMUP[i].backup_raw, WARMUP[i].typed, WARMUP[i].want);

    // random batches across register settings, calm at the end
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain_reports();
        case (p)
          1: program_limits('0, '0, '0, '0);
          2: program_limits('1, '1, '1, '1);
          3: program_limits(13'd2000, 13'd2000, 13'd6000, 13'd6000);
          default: program_limits(btms_pkg::CFG_DAT_W'($urandom_range(0, 2000)),
                                  btms_pkg::CFG_DAT_W'($urandom_range(0, 2000)),
                                  btms_pkg::CFG_DAT_W'($urandom_range(0, 6000)),
                                  btms_pkg::CFG_DAT_W'($urandom_range(0, 6000)));
        endcase
      end
      idle_on       = (p % 3 != 2) && (p != PHASES - 1);
      pause_pending = (p == 1);
      repeat (PHASE_BATCHES) play_batch();
    end

    drain_reports();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
